// ===== sv/melody_note_parser_macros.svh =====
// assertion macros shared by the melody note parser modules
// expects signals named clock and reset in the module that uses them
`ifndef MELODY_NOTE_PARSER_MACROS_SVH
`define MELODY_NOTE_PARSER_MACROS_SVH

// checked only outside reset
`define MNP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define MNP_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/mnp_pkg.sv =====
// constants, lookup tables and types for the melody note parser
// no dependencies; used by the interfaces and every module
package mnp_pkg;

   localparam longint unsigned PWM_CLOCK_HZ = 64'd1000000;
   localparam longint unsigned SEMIBREVE_MS = 64'd500;

   localparam int CHAR_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int PERIOD_W   = 16;
   localparam int DURATION_W = 12;
   localparam int NOTE_W     = 4;
   localparam int DIGIT_W    = 4;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
   localparam logic [CHAR_W-1:0] CH_P     = 8'h50;

   localparam logic [DIGIT_W-1:0] DEFAULT_OCTAVE   = 4'd4;
   localparam logic [DIGIT_W-1:0] DEFAULT_FRACTION = 4'd4;
   localparam logic [NOTE_W-1:0]  SEMITONES        = 4'd12;

   typedef enum logic [STATUS_W-1:0] {
      ST_TONE  = 2'd0,
      ST_PAUSE = 2'd1,
      ST_ERROR = 2'd2,
      ST_END   = 2'd3
   } status_type;

   // octave-4 frequencies in millihertz
   localparam longint unsigned FREQ4_MHZ [12] = '{
      64'd261626, 64'd277183, 64'd293665, 64'd311127, 64'd329628, 64'd349228,
      64'd369994, 64'd391995, 64'd415305, 64'd440000, 64'd466164, 64'd493883
   };

   // octave-0 periods; any octave is a right shift of these
   localparam longint unsigned PERIOD_NUM = PWM_CLOCK_HZ * 64'd16000;
   localparam int PERIOD_BASE_W = $clog2(PERIOD_NUM / FREQ4_MHZ[0] + 64'd1);
   localparam int PERIOD_CALC_W = (PERIOD_BASE_W > PERIOD_W) ? PERIOD_BASE_W : PERIOD_W;
   localparam logic [PERIOD_CALC_W-1:0] PERIOD_SAT = PERIOD_CALC_W'({PERIOD_W{1'b1}});

   localparam logic [PERIOD_CALC_W-1:0] PERIOD_BASE [12] = '{
      PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[0]),  PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[1]),
      PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[2]),  PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[3]),
      PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[4]),  PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[5]),
      PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[6]),  PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[7]),
      PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[8]),  PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[9]),
      PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[10]), PERIOD_CALC_W'(PERIOD_NUM / FREQ4_MHZ[11])
   };

   // duration by fraction digit; zero is treated as one
   localparam logic [DURATION_W-1:0] LENGTH_MS_LUT [16] = '{
      DURATION_W'(SEMIBREVE_MS / 64'd1),  DURATION_W'(SEMIBREVE_MS / 64'd1),
      DURATION_W'(SEMIBREVE_MS / 64'd2),  DURATION_W'(SEMIBREVE_MS / 64'd3),
      DURATION_W'(SEMIBREVE_MS / 64'd4),  DURATION_W'(SEMIBREVE_MS / 64'd5),
      DURATION_W'(SEMIBREVE_MS / 64'd6),  DURATION_W'(SEMIBREVE_MS / 64'd7),
      DURATION_W'(SEMIBREVE_MS / 64'd8),  DURATION_W'(SEMIBREVE_MS / 64'd9),
      DURATION_W'(SEMIBREVE_MS / 64'd10), DURATION_W'(SEMIBREVE_MS / 64'd11),
      DURATION_W'(SEMIBREVE_MS / 64'd12), DURATION_W'(SEMIBREVE_MS / 64'd13),
      DURATION_W'(SEMIBREVE_MS / 64'd14), DURATION_W'(SEMIBREVE_MS / 64'd15)
   };

   // semitone of A..G above C
   localparam logic [NOTE_W-1:0] LETTER_POS [7] = '{
      4'd9, 4'd11, 4'd0, 4'd2, 4'd4, 4'd5, 4'd7
   };

   typedef struct packed {
      status_type          status;
      logic                last;
      logic [NOTE_W-1:0]   semitone;
      logic                sharp;
      logic [DIGIT_W-1:0]  octave;
      logic [DIGIT_W-1:0]  fraction;
   } parse_result_type;

   typedef struct packed {
      status_type             status;
      logic [PERIOD_W-1:0]    period_counts;
      logic [DURATION_W-1:0]  length_ms;
      logic                   last;
   } rsp_payload_type;

endpackage

// ===== sv/mnp_if.sv =====
// valid/ready stream interfaces for melody text bytes and tone commands
// depends on mnp_pkg
interface mnp_req_if import mnp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface mnp_rsp_if import mnp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [PERIOD_W-1:0]   period_counts;
   logic [DURATION_W-1:0] length_ms;
   logic                  last;

   modport source (output valid, output status, output period_counts,
                   output length_ms, output last, input ready);
   modport sink (input valid, input status, input period_counts,
                 input length_ms, input last, output ready);
endinterface

// ===== sv/melody_note_parser.sv =====
// melody note parser top level: input byte register, parser, tone lookup, result register
// depends on mnp_pkg, mnp_if, mnp_parser, mnp_tone and melody_note_parser_macros.svh
//
// req_chan carries melody text one byte per transfer; rsp_chan carries tone commands
// (status, period_counts, length_ms, last). a space ends a token and gives one
// command, a zero byte ends the melody and gives one command with last set, an
// error gives a command with last set and then drops bytes up to and including the
// zero byte; bytes inside a token give no command
// a byte taken from req_chan is held in the input register, parsed from there, and
// its command is loaded into the result register, which drives rsp_chan.valid
// throughput: one byte per cycle while rsp_chan does not stall, set by the
// combinational parse and table lookup between the input and result registers
// when rsp_chan stalls, bytes that give no command still go through; a byte that
// gives a command waits in the input register and req_chan.ready stays low until
// the pending command is taken
// reset empties both registers and puts the parser at token start with defaults
`include "melody_note_parser_macros.svh"

module melody_note_parser import mnp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   mnp_req_if.sink       req_chan,
   mnp_rsp_if.source     rsp_chan
);

   logic               in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]  in_char_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff;

   logic               emit;
   logic               advance;
   logic               req_xfer;
   parse_result_type   result;
   rsp_payload_type    payload;

   mnp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .emit      (emit),
      .result    (result)
   );

   mnp_tone u_tone (
      .result  (result),
      .payload (payload)
   );

   always_comb begin
      advance        = in_valid_ff && (!emit || !rsp_valid_ff || rsp_chan.ready);
      req_chan.ready = !in_valid_ff || advance;
      req_xfer       = req_chan.valid && req_chan.ready;

      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         in_char_ff <= req_chan.char_code;
      end
      if (advance && emit) begin
         rsp_data_ff <= payload;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_data_ff.status;
   assign rsp_chan.period_counts = rsp_data_ff.period_counts;
   assign rsp_chan.length_ms     = rsp_data_ff.length_ms;
   assign rsp_chan.last          = rsp_data_ff.last;

   `MNP_ASSERT(a_no_overwrite, advance && emit && rsp_valid_ff |-> rsp_chan.ready, "result register overwritten before transfer")
   `MNP_ASSERT_RST(a_reset_empty, $past(reset) |-> !rsp_valid_ff && !in_valid_ff, "registers not empty after reset")

endmodule

// ===== sv/mnp_parser.sv =====
// token parser: phase state machine and held note fields, one byte per step
// depends on mnp_pkg and melody_note_parser_macros.svh
`include "melody_note_parser_macros.svh"

module mnp_parser import mnp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [CHAR_W-1:0] char_code,
   output logic              emit,
   output parse_result_type  result
);

   typedef enum logic [2:0] {
      PH_START,
      PH_NAME,
      PH_SHARP,
      PH_OCT,
      PH_SLASH,
      PH_SKIP
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [NOTE_W-1:0]    semitone_ff, semitone_in;
   logic                 pause_ff, pause_in;
   logic                 sharp_ff, sharp_in;
   logic [DIGIT_W-1:0]   octave_ff, octave_in;
   logic [DIGIT_W-1:0]   fraction_ff, fraction_in;
   logic                 halted_ff, halted_in;

   logic                 is_nul;
   logic                 is_digit;
   logic                 is_frac_digit;
   logic                 is_letter;
   logic                 do_fail;
   logic                 clear_token;
   logic [CHAR_W-1:0]    letter_off;
   logic [CHAR_W-1:0]    digit_val;

   always_comb begin
      is_nul        = (char_code == CH_NUL);
      is_digit      = char_code inside {[CH_ZERO:CH_NINE]};
      is_frac_digit = char_code inside {[CH_ONE:CH_NINE]};
      is_letter     = char_code inside {[CH_A:CH_G]};
      letter_off    = char_code - CH_A;
      digit_val     = char_code - CH_ZERO;

      phase_in    = phase_ff;
      semitone_in = semitone_ff;
      pause_in    = pause_ff;
      sharp_in    = sharp_ff;
      octave_in   = octave_ff;
      fraction_in = fraction_ff;
      halted_in   = halted_ff;
      do_fail     = 1'b0;
      clear_token = 1'b0;
      emit        = 1'b0;

      result.status   = pause_ff ? ST_PAUSE : ST_TONE;
      result.last     = is_nul;
      result.semitone = semitone_ff;
      result.sharp    = sharp_ff;
      result.octave   = octave_ff;
      result.fraction = fraction_ff;

      if (halted_ff) begin
         if (is_nul) begin
            halted_in   = 1'b0;
            clear_token = 1'b1;
         end
      end else if (phase_ff == PH_START) begin
         clear_token = 1'b1;
         if (is_nul) begin
            emit          = 1'b1;
            result.status = ST_END;
            result.last   = 1'b1;
         end else if (char_code == CH_P) begin
            clear_token = 1'b0;
            semitone_in = '0;
            sharp_in    = 1'b0;
            octave_in   = DEFAULT_OCTAVE;
            fraction_in = DEFAULT_FRACTION;
            pause_in    = 1'b1;
            phase_in    = PH_OCT;
         end else if (is_letter) begin
            clear_token = 1'b0;
            semitone_in = LETTER_POS[letter_off[2:0]];
            sharp_in    = 1'b0;
            pause_in    = 1'b0;
            octave_in   = DEFAULT_OCTAVE;
            fraction_in = DEFAULT_FRACTION;
            phase_in    = PH_NAME;
         end else begin
            do_fail = 1'b1;
         end
      end else if (is_nul || char_code == CH_SPACE) begin
         if (phase_ff == PH_SLASH) begin
            do_fail = 1'b1;
         end else begin
            emit        = 1'b1;
            clear_token = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_NAME: begin
               if (char_code == CH_HASH) begin
                  sharp_in = 1'b1;
                  phase_in = PH_SHARP;
               end else if (is_digit) begin
                  octave_in = digit_val[DIGIT_W-1:0];
                  phase_in  = PH_OCT;
               end else if (char_code == CH_SLASH) begin
                  phase_in = PH_SLASH;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SHARP: begin
               if (is_digit) begin
                  octave_in = digit_val[DIGIT_W-1:0];
                  phase_in  = PH_OCT;
               end else if (char_code == CH_SLASH) begin
                  phase_in = PH_SLASH;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_OCT: begin
               phase_in = (char_code == CH_SLASH) ? PH_SLASH : PH_SKIP;
            end
            PH_SLASH: begin
               if (is_frac_digit) begin
                  fraction_in = digit_val[DIGIT_W-1:0];
                  phase_in    = PH_SKIP;
               end else begin
                  do_fail = 1'b1;
               end
            end
            default: begin
               phase_in = PH_SKIP;
            end
         endcase
      end

      if (do_fail) begin
         emit          = 1'b1;
         result.status = ST_ERROR;
         result.last   = 1'b1;
         clear_token   = 1'b1;
         halted_in     = !is_nul;
      end

      if (clear_token) begin
         phase_in    = PH_START;
         semitone_in = '0;
         pause_in    = 1'b0;
         sharp_in    = 1'b0;
         octave_in   = DEFAULT_OCTAVE;
         fraction_in = DEFAULT_FRACTION;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         semitone_ff <= '0;
         pause_ff    <= 1'b0;
         sharp_ff    <= 1'b0;
         octave_ff   <= DEFAULT_OCTAVE;
         fraction_ff <= DEFAULT_FRACTION;
         halted_ff   <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         semitone_ff <= semitone_in;
         pause_ff    <= pause_in;
         sharp_ff    <= sharp_in;
         octave_ff   <= octave_in;
         fraction_ff <= fraction_in;
         halted_ff   <= halted_in;
      end
   end

   `MNP_ASSERT(a_halt_at_start, halted_ff |-> phase_ff == PH_START, "halted mid-token")
   `MNP_ASSERT(a_nul_restarts, step && is_nul |=> !halted_ff && phase_ff == PH_START, "end byte did not restart parsing")

endmodule

// ===== sv/mnp_tone.sv =====
// tone lookup: period from semitone and octave, duration from fraction
// depends on mnp_pkg
module mnp_tone import mnp_pkg::*; (
   input  parse_result_type result,
   output rsp_payload_type  payload
);

   logic [NOTE_W:0]             pos_sum;
   logic [NOTE_W-1:0]           pos;
   logic [DIGIT_W-1:0]          oct;
   logic [PERIOD_CALC_W-1:0]    shifted;
   logic [PERIOD_W-1:0]         period;
   logic [DURATION_W-1:0]       duration;

   always_comb begin
      pos_sum = {1'b0, result.semitone} + {{NOTE_W{1'b0}}, result.sharp};
      if (pos_sum >= {1'b0, SEMITONES}) begin
         // b sharp wraps to c of the next octave
         pos = pos_sum[NOTE_W-1:0] - SEMITONES;
         oct = result.octave + 4'd1;
      end else begin
         pos = pos_sum[NOTE_W-1:0];
         oct = result.octave;
      end
      shifted  = PERIOD_BASE[pos] >> oct;
      period   = (shifted > PERIOD_SAT) ? PERIOD_SAT[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
      duration = LENGTH_MS_LUT[result.fraction];

      payload.status = result.status;
      payload.last   = result.last;
      case (result.status)
         ST_TONE: begin
            payload.period_counts = period;
            payload.length_ms     = duration;
         end
         ST_PAUSE: begin
            payload.period_counts = '0;
            payload.length_ms     = duration;
         end
         default: begin
            payload.period_counts = '0;
            payload.length_ms     = '0;
         end
      endcase
   end

endmodule
